@@ src/ttc_pkg.sv @@
// shared types and constants for the text terminal cursor engine
package ttc_pkg;

  // depth of the per-item result queue
  localparam int RES_DEPTH = 16;

  // character and control codes
  localparam logic [7:0] CH_BS         = 8'd8;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_LAST_PRINT = 8'd127;

  // configuration register indexes
  localparam logic [1:0] REG_WRAP    = 2'd0;
  localparam logic [1:0] REG_SCROLL  = 2'd1;
  localparam logic [1:0] REG_OVERLAY = 2'd2;

  typedef enum logic [1:0] {
    ACT_CHAR         = 2'd0,
    ACT_SET_CURSOR   = 2'd1,
    ACT_CLEAR_SCREEN = 2'd2,
    ACT_READ_CELL    = 2'd3
  } ttc_action_t;

  typedef enum logic [2:0] {
    OP_DRAW       = 3'd0,
    OP_CLEAR_EOL  = 3'd1,
    OP_SCROLL     = 3'd2,
    OP_CLEAR_SCRN = 3'd3,
    OP_CELL_READ  = 3'd4,
    OP_CURSOR     = 3'd5
  } ttc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_PUT,
    ST_FILL,
    ST_DOWN,
    ST_LINE_HOME,
    ST_DRAIN
  } ttc_state_t;

  typedef struct packed {
    ttc_action_t action;
    logic [7:0]  char_code;
    logic [7:0]  col;
    logic [7:0]  row;
  } ttc_cmd_t;

  typedef struct packed {
    ttc_op_t    op;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [7:0] cell_char;
    logic       clear_background;
    logic       last;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } ttc_res_t;

  // draw command before the final cursor is known
  typedef struct packed {
    ttc_op_t    op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] ch;
    logic       bg;
  } ttc_entry_t;

  // page store access, logical row and column
  typedef struct packed {
    logic       wr;
    logic       unblank;
    logic       scroll;
    logic       clear_all;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] ch;
  } ttc_page_req_t;

endpackage

@@ src/text_terminal_cursor_engine_top.sv @@
// text terminal cursor engine: command decode, cursor and page sequencing
// a plain character passes decode, write and queue to the output register;
// its results then leave one per cycle while res_stall is low
// one item at a time; each further result adds a drain step, each tab space
// past the first a put step, a row step a down state, and the first glyph
// into a blank row a sweep of that row to spaces before its put
// reset: synchronous, clears cursor, sets wrap and scroll, marks all rows blank
module text_terminal_cursor_engine_top #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  ttc_pkg::ttc_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output ttc_pkg::ttc_res_t res,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [0:0]        cfg_data
);

  ttc_pkg::ttc_state_t state, state_next;

  // cursor and configuration
  logic [7:0] cur_x, cur_y;
  logic       wrap_en, scroll_en, overlay;

  // latched item and sequencing state
  ttc_pkg::ttc_cmd_t item;
  logic [7:0]        put_ch;
  logic [3:0]        tab_cnt;
  logic              nl_pend;
  logic [7:0]        fill_cnt;

  // page store and result queue hookup
  ttc_pkg::ttc_page_req_t req;
  logic [7:0]             rd_data;
  logic                   row_blank;
  logic                   push;
  ttc_pkg::ttc_entry_t    entry;
  logic                   drain_done;

  // derived conditions
  logic       x_out, y_out, cur_out;
  logic       printable;
  logic [8:0] stop_raw, stop;
  logic [3:0] tab_n;
  logic       put_wrap;
  logic [8:0] y_inc;
  logic       down_in;
  logic       bs_out;
  logic       read_in;
  logic       need_fill;
  logic       more_puts;

  always_comb begin
    x_out     = cur_x >= 8'(COLUMNS);
    y_out     = cur_y >= 8'(ROWS);
    cur_out   = x_out || y_out;
    printable = (item.char_code >= ttc_pkg::CH_SPACE) &&
                (item.char_code <= ttc_pkg::CH_LAST_PRINT);
    // next tab stop is the next multiple of 8, capped at the row end
    stop_raw  = {({1'b0, cur_x[7:3]} + 6'd1), 3'b000};
    stop      = (stop_raw > 9'(COLUMNS)) ? 9'(COLUMNS) : stop_raw;
    tab_n     = 4'(stop - {1'b0, cur_x});
    put_wrap  = wrap_en && (({1'b0, cur_x} + 9'd1) >= 9'(COLUMNS));
    y_inc     = {1'b0, cur_y} + 9'd1;
    down_in   = y_inc < 9'(ROWS);
    bs_out    = ((cur_x - 8'd1) >= 8'(COLUMNS)) || y_out;
    read_in   = (item.col < 8'(COLUMNS)) && (item.row < 8'(ROWS));
    // a glyph into a blank row needs the row swept to spaces first
    need_fill = row_blank && (put_ch != ttc_pkg::CH_SPACE);
    more_puts = tab_cnt > 4'd1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ttc_pkg::ST_DECODE;
        end
      end
      ttc_pkg::ST_DECODE: begin
        unique case (item.action)
          ttc_pkg::ACT_SET_CURSOR:   state_next = ttc_pkg::ST_DRAIN;
          ttc_pkg::ACT_CLEAR_SCREEN: state_next = ttc_pkg::ST_DRAIN;
          ttc_pkg::ACT_READ_CELL:    state_next = ttc_pkg::ST_READ;
          ttc_pkg::ACT_CHAR: begin
            unique case (item.char_code)
              ttc_pkg::CH_BS:  state_next = ttc_pkg::ST_DRAIN;
              ttc_pkg::CH_TAB: state_next = cur_out ? ttc_pkg::ST_DRAIN : ttc_pkg::ST_PUT;
              ttc_pkg::CH_LF:  state_next = ttc_pkg::ST_DOWN;
              ttc_pkg::CH_CR:  state_next = ttc_pkg::ST_LINE_HOME;
              default:         state_next = printable ? ttc_pkg::ST_PUT : ttc_pkg::ST_DRAIN;
            endcase
          end
        endcase
      end
      ttc_pkg::ST_READ: state_next = ttc_pkg::ST_DRAIN;
      ttc_pkg::ST_PUT: begin
        priority if (cur_out) begin
          state_next = more_puts ? ttc_pkg::ST_PUT : ttc_pkg::ST_DRAIN;
        end else if (need_fill) begin
          state_next = ttc_pkg::ST_FILL;
        end else if (put_wrap) begin
          state_next = ttc_pkg::ST_DOWN;
        end else begin
          state_next = more_puts ? ttc_pkg::ST_PUT : ttc_pkg::ST_DRAIN;
        end
      end
      ttc_pkg::ST_FILL: begin
        if (fill_cnt == 8'(COLUMNS - 1)) begin
          state_next = ttc_pkg::ST_PUT;
        end
      end
      ttc_pkg::ST_DOWN: begin
        priority if (nl_pend) begin
          state_next = ttc_pkg::ST_LINE_HOME;
        end else if (tab_cnt != 4'd0) begin
          state_next = ttc_pkg::ST_PUT;
        end else begin
          state_next = ttc_pkg::ST_DRAIN;
        end
      end
      ttc_pkg::ST_LINE_HOME: state_next = ttc_pkg::ST_DRAIN;
      ttc_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_next = ttc_pkg::ST_IDLE;
        end
      end
      default: state_next = ttc_pkg::ST_IDLE;
    endcase
  end

  // page requests and draw commands per state
  always_comb begin
    req     = '0;
    req.row = cur_y;
    req.col = cur_x;
    req.ch  = put_ch;
    push    = 1'b0;
    entry   = '0;
    unique case (state)
      ttc_pkg::ST_DECODE: begin
        if (item.action == ttc_pkg::ACT_CLEAR_SCREEN) begin
          req.clear_all = 1'b1;
          push          = 1'b1;
          entry.op      = ttc_pkg::OP_CLEAR_SCRN;
          entry.bg      = 1'b1;
        end else if (item.action == ttc_pkg::ACT_READ_CELL) begin
          req.row = item.row;
          req.col = item.col;
        end else if (item.action == ttc_pkg::ACT_CHAR && item.char_code == ttc_pkg::CH_BS &&
                     cur_x != 8'd0 && !bs_out) begin
          // backspace blanks the cell to the left; a blank row already reads as space
          req.col  = cur_x - 8'd1;
          req.ch   = ttc_pkg::CH_SPACE;
          req.wr   = !row_blank;
          push     = 1'b1;
          entry.op = ttc_pkg::OP_DRAW;
          entry.col = cur_x - 8'd1;
          entry.row = cur_y;
          entry.ch  = ttc_pkg::CH_SPACE;
          entry.bg  = !overlay;
        end
      end
      ttc_pkg::ST_READ: begin
        req.row   = item.row;
        req.col   = item.col;
        push      = 1'b1;
        entry.op  = ttc_pkg::OP_CELL_READ;
        entry.col = item.col;
        entry.row = item.row;
        entry.ch  = !read_in ? 8'd0 : (row_blank ? ttc_pkg::CH_SPACE : rd_data);
      end
      ttc_pkg::ST_PUT: begin
        if (!cur_out && !need_fill) begin
          req.wr    = !row_blank;
          push      = 1'b1;
          entry.op  = ttc_pkg::OP_DRAW;
          entry.col = cur_x;
          entry.row = cur_y;
          entry.ch  = put_ch;
          entry.bg  = !overlay;
        end
      end
      ttc_pkg::ST_FILL: begin
        req.col     = fill_cnt;
        req.ch      = ttc_pkg::CH_SPACE;
        req.wr      = 1'b1;
        req.unblank = fill_cnt == 8'(COLUMNS - 1);
      end
      ttc_pkg::ST_DOWN: begin
        if (!down_in && scroll_en) begin
          req.scroll = 1'b1;
          push       = 1'b1;
          entry.op   = ttc_pkg::OP_SCROLL;
          entry.row  = 8'(ROWS - 1);
          entry.bg   = 1'b1;
        end
      end
      ttc_pkg::ST_LINE_HOME: begin
        if (!overlay) begin
          push      = 1'b1;
          entry.op  = ttc_pkg::OP_CLEAR_EOL;
          entry.col = cur_x;
          entry.row = cur_y;
          entry.bg  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // latched item
  always_ff @(posedge clk) begin
    if (state == ttc_pkg::ST_IDLE && cmd_valid) begin
      item <= cmd;
    end
  end

  // state, cursor, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ttc_pkg::ST_IDLE;
      cur_x     <= '0;
      cur_y     <= '0;
      wrap_en   <= 1'b1;
      scroll_en <= 1'b1;
      overlay   <= 1'b0;
      nl_pend   <= 1'b0;
      tab_cnt   <= '0;
      fill_cnt  <= '0;
      put_ch    <= ttc_pkg::CH_SPACE;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          ttc_pkg::REG_WRAP:    wrap_en   <= cfg_data[0];
          ttc_pkg::REG_SCROLL:  scroll_en <= cfg_data[0];
          ttc_pkg::REG_OVERLAY: overlay   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      unique case (state)
        ttc_pkg::ST_DECODE: begin
          unique case (item.action)
            ttc_pkg::ACT_SET_CURSOR: begin
              cur_x <= item.col;
              cur_y <= item.row;
            end
            ttc_pkg::ACT_CLEAR_SCREEN: begin
              cur_x <= '0;
              cur_y <= '0;
            end
            ttc_pkg::ACT_READ_CELL: begin
            end
            ttc_pkg::ACT_CHAR: begin
              unique case (item.char_code)
                ttc_pkg::CH_BS: begin
                  if (cur_x != 8'd0) begin
                    if (bs_out) begin
                      cur_x <= '0;
                      cur_y <= '0;
                    end else begin
                      cur_x <= cur_x - 8'd1;
                    end
                  end
                end
                ttc_pkg::CH_TAB: begin
                  if (cur_out) begin
                    cur_x <= '0;
                    cur_y <= '0;
                  end else begin
                    put_ch  <= ttc_pkg::CH_SPACE;
                    tab_cnt <= tab_n;
                  end
                end
                ttc_pkg::CH_LF: nl_pend <= 1'b1;
                ttc_pkg::CH_CR: begin
                end
                default: begin
                  if (printable) begin
                    put_ch  <= item.char_code;
                    tab_cnt <= 4'd1;
                  end else if (cur_out) begin
                    // ignored code still homes a stray cursor
                    cur_x <= '0;
                    cur_y <= '0;
                  end
                end
              endcase
            end
          endcase
        end
        ttc_pkg::ST_PUT: begin
          fill_cnt <= '0;
          if (cur_out) begin
            cur_x   <= '0;
            cur_y   <= '0;
            tab_cnt <= tab_cnt - 4'd1;
          end else if (!need_fill) begin
            tab_cnt <= tab_cnt - 4'd1;
            cur_x   <= put_wrap ? 8'd0 : cur_x + 8'd1;
          end
        end
        ttc_pkg::ST_FILL: fill_cnt <= fill_cnt + 8'd1;
        ttc_pkg::ST_DOWN: begin
          // bottom row scrolls the page or rolls back to the top
          if (down_in) begin
            cur_y <= y_inc[7:0];
          end else if (!scroll_en) begin
            cur_y <= '0;
          end else begin
            cur_y <= 8'(ROWS - 1);
          end
        end
        ttc_pkg::ST_LINE_HOME: begin
          cur_x   <= '0;
          nl_pend <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_stall = state != ttc_pkg::ST_IDLE;

  ttc_page #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_page (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rd_data   (rd_data),
    .row_blank (row_blank)
  );

  // every result of an item carries the cursor as left after the item
  ttc_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry      (entry),
    .drain      (state == ttc_pkg::ST_DRAIN),
    .cursor_col (cur_x),
    .cursor_row (cur_y),
    .res_stall  (res_stall),
    .res_valid  (res_valid),
    .res        (res),
    .drain_done (drain_done)
  );

endmodule

@@ src/ttc_page.sv @@
// character page memory with rotating top row and per-row blank marks
module ttc_page #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ttc_pkg::ttc_page_req_t req,
  output logic [7:0]            rd_data,
  output logic                  row_blank
);

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);

  logic [7:0]    mem [DEPTH];
  logic [RW-1:0] top;
  logic [ROWS-1:0] blank;
  logic [RW:0]   sum;
  logic [RW-1:0] phys;
  logic [AW-1:0] addr;

  // logical row to physical row, page rotates on scroll
  always_comb begin
    sum  = {1'b0, top} + {1'b0, req.row[RW-1:0]};
    phys = (sum >= (RW+1)'(ROWS)) ? RW'(sum - (RW+1)'(ROWS)) : sum[RW-1:0];
    addr = AW'(phys) * AW'(COLUMNS) + AW'(req.col);
  end

  assign row_blank = blank[phys];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= req.ch;
    end
    rd_data <= mem[addr];
  end

  // a blank row reads as spaces until it is swept and written
  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      blank <= '1;
    end else begin
      if (req.clear_all) begin
        blank <= '1;
      end else if (req.scroll) begin
        blank[top] <= 1'b1;
        top        <= (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
      end else if (req.unblank) begin
        blank[phys] <= 1'b0;
      end
    end
  end

endmodule

@@ src/ttc_result_queue.sv @@
// result queue and output register, attaches final cursor and last flag
module ttc_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ttc_pkg::ttc_entry_t entry,
  input  logic                drain,
  input  logic [7:0]          cursor_col,
  input  logic [7:0]          cursor_row,
  input  logic                res_stall,
  output logic                res_valid,
  output ttc_pkg::ttc_res_t   res,
  output logic                drain_done
);

  localparam int IW = $clog2(ttc_pkg::RES_DEPTH);
  localparam int CW = $clog2(ttc_pkg::RES_DEPTH + 1);

  ttc_pkg::ttc_entry_t slots [ttc_pkg::RES_DEPTH];
  logic [CW-1:0]       cnt;
  logic [IW-1:0]       rd;
  ttc_pkg::ttc_entry_t cur;
  logic                is_last;
  logic                load;

  always_comb begin
    if (cnt == '0) begin
      cur    = '0;
      cur.op = ttc_pkg::OP_CURSOR;
    end else begin
      cur = slots[rd];
    end
    is_last    = (cnt == '0) || (CW'(rd) == cnt - CW'(1));
    load       = drain && (!res_valid || !res_stall);
    drain_done = load && is_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[cnt[IW-1:0]] <= entry;
    end
    if (load) begin
      res.op               <= cur.op;
      res.cell_col         <= cur.col;
      res.cell_row         <= cur.row;
      res.cell_char        <= cur.ch;
      res.clear_background <= cur.bg;
      res.last             <= is_last;
      res.cursor_col       <= cursor_col;
      res.cursor_row       <= cursor_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (drain_done) begin
        cnt <= '0;
        rd  <= '0;
      end else begin
        if (push) begin
          cnt <= cnt + CW'(1);
        end
        if (load) begin
          rd <= rd + IW'(1);
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/ttc_checker.sv @@
// port-level checks for the text terminal cursor engine, bound to the top level
module ttc_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input ttc_pkg::ttc_cmd_t cmd,
  input logic              res_valid,
  input logic              res_stall,
  input ttc_pkg::ttc_res_t res
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // an accepted item keeps the command side busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while previous one in work");

  // results of one item follow back to back
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !res.last |=> res_valid)
    else $error("gap inside the results of one item");

  // no new item while results of the current one remain
  a_stall_until_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> cmd_stall)
    else $error("command taken before last result");

  // cursor-only and cell-read results stand alone and never clear background
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.op == ttc_pkg::OP_CURSOR || res.op == ttc_pkg::OP_CELL_READ)
      |-> res.last && !res.clear_background)
    else $error("bad cursor-only or cell-read result");

  logic unused_cmd;
  assign unused_cmd = ^cmd;

endmodule

bind text_terminal_cursor_engine_top ttc_checker u_ttc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

@@ test/ttc_draw_checker.sv @@
// checker for the terminal engine: page and cursor prediction, result comparison
module ttc_draw_checker #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  ttc_pkg::ttc_cmd_t cmd,
  input  logic              res_valid,
  input  logic              res_stall,
  input  ttc_pkg::ttc_res_t res,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [0:0]        cfg_data,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int MAX_DRAWS = 16;

  logic [7:0] page [CELLS];
  int cur_x, cur_y;
  bit wrap_on, scroll_on, overlay_on;
  ttc_pkg::ttc_res_t item_draws[$];
  ttc_pkg::ttc_res_t expected_draws[$];

  task automatic report(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("t=%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void emit(ttc_pkg::ttc_op_t op, int c, int r, int ch, bit bg);
    ttc_pkg::ttc_res_t d;
    if (item_draws.size() >= MAX_DRAWS) begin
      return;
    end
    d = '0;
    d.op = op;
    d.cell_col = 8'(c);
    d.cell_row = 8'(r);
    d.cell_char = 8'(ch);
    d.clear_background = bg;
    item_draws.push_back(d);
  endfunction

  function automatic bit cursor_off_page();
    return cur_x >= COLUMNS || cur_y >= ROWS;
  endfunction

  function automatic void home();
    cur_x = 0;
    cur_y = 0;
  endfunction

  // move down one row: scroll the page or roll back to the top
  function automatic void line_down();
    int y;
    y = cur_y + 1;
    if (y < ROWS) begin
      cur_y = y;
    end else if (!scroll_on) begin
      cur_y = 0;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) page[i] = page[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) page[i] = ttc_pkg::CH_SPACE;
      cur_y = ROWS - 1;
      emit(ttc_pkg::OP_SCROLL, 0, ROWS - 1, 0, 1'b1);
    end
  endfunction

  function automatic void step_right();
    cur_x++;
    if (wrap_on && cur_x >= COLUMNS) begin
      cur_x = 0;
      line_down();
    end
  endfunction

  function automatic void put_glyph(logic [7:0] ch);
    if (cursor_off_page()) begin
      home();
      return;
    end
    if (ch < ttc_pkg::CH_SPACE || ch > ttc_pkg::CH_LAST_PRINT) begin
      return;
    end
    page[cur_y * COLUMNS + cur_x] = ch;
    emit(ttc_pkg::OP_DRAW, cur_x, cur_y, ch, !overlay_on);
    step_right();
  endfunction

  function automatic void line_start();
    if (!overlay_on) begin
      emit(ttc_pkg::OP_CLEAR_EOL, cur_x, cur_y, 0, 1'b1);
    end
    cur_x = 0;
  endfunction

  function automatic void handle_code(logic [7:0] ch);
    int stop;
    case (ch)
      ttc_pkg::CH_BS: begin
        if (cur_x > 0) begin
          if (cur_x - 1 >= COLUMNS || cur_y >= ROWS) begin
            home();
          end else begin
            cur_x--;
            page[cur_y * COLUMNS + cur_x] = ttc_pkg::CH_SPACE;
            emit(ttc_pkg::OP_DRAW, cur_x, cur_y, ttc_pkg::CH_SPACE, !overlay_on);
          end
        end
      end
      ttc_pkg::CH_TAB: begin
        if (cursor_off_page()) begin
          home();
        end else begin
          stop = (cur_x / 8 + 1) * 8;
          if (stop > COLUMNS) stop = COLUMNS;
          for (int k = stop - cur_x; k > 0; k--) put_glyph(ttc_pkg::CH_SPACE);
        end
      end
      ttc_pkg::CH_LF: begin
        line_down();
        line_start();
      end
      ttc_pkg::CH_CR: line_start();
      default: put_glyph(ch);
    endcase
  endfunction

  // turn one accepted command into its list of draw commands
  function automatic void predict_draw_commands(ttc_pkg::ttc_cmd_t c);
    item_draws.delete();
    case (c.action)
      ttc_pkg::ACT_CHAR: handle_code(c.char_code);
      ttc_pkg::ACT_SET_CURSOR: begin
        cur_x = c.col;
        cur_y = c.row;
      end
      ttc_pkg::ACT_CLEAR_SCREEN: begin
        for (int i = 0; i < CELLS; i++) page[i] = ttc_pkg::CH_SPACE;
        home();
        emit(ttc_pkg::OP_CLEAR_SCRN, 0, 0, 0, 1'b1);
      end
      default: begin
        emit(ttc_pkg::OP_CELL_READ, c.col, c.row,
             (c.col < COLUMNS && c.row < ROWS) ? page[c.row * COLUMNS + c.col] : 8'd0,
             1'b0);
      end
    endcase
    if (item_draws.size() == 0) begin
      emit(ttc_pkg::OP_CURSOR, 0, 0, 0, 1'b0);
    end
    item_draws[item_draws.size() - 1].last = 1'b1;
    foreach (item_draws[k]) begin
      item_draws[k].cursor_col = 8'(cur_x);
      item_draws[k].cursor_row = 8'(cur_y);
      expected_draws.push_back(item_draws[k]);
    end
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    ttc_pkg::ttc_res_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) page[i] = ttc_pkg::CH_SPACE;
      home();
      wrap_on = 1'b1;
      scroll_on = 1'b1;
      overlay_on = 1'b0;
      expected_draws.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ttc_pkg::REG_WRAP:    wrap_on = cfg_data[0];
          ttc_pkg::REG_SCROLL:  scroll_on = cfg_data[0];
          ttc_pkg::REG_OVERLAY: overlay_on = cfg_data[0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (expected_draws.size() == 0) begin
          report("result with nothing expected, op", int'(res.op), -1);
        end else begin
          want = expected_draws.pop_front();
          if (res.op != want.op) report("op", int'(res.op), int'(want.op));
          if (res.cell_col != want.cell_col) report("cell_col", res.cell_col, want.cell_col);
          if (res.cell_row != want.cell_row) report("cell_row", res.cell_row, want.cell_row);
          if (res.cell_char != want.cell_char)
            report("cell_char", res.cell_char, want.cell_char);
          if (res.clear_background != want.clear_background)
            report("clear_background", res.clear_background, want.clear_background);
          if (res.last != want.last) report("last", res.last, want.last);
          if (res.cursor_col != want.cursor_col)
            report("cursor_col", res.cursor_col, want.cursor_col);
          if (res.cursor_row != want.cursor_row)
            report("cursor_row", res.cursor_row, want.cursor_row);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        predict_draw_commands(cmd);
      end
    end
    outstanding = expected_draws.size();
  end

endmodule

@@ test/text_terminal_cursor_engine_top_tb.sv @@
// testbench top for the text terminal cursor engine: stimulus and verdict
module text_terminal_cursor_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 64;
  localparam int ROWS = 16;
  // watchdog limit for the whole run, above a full result burst under stalls plus a row sweep per item
  localparam int CYCLE_LIMIT = 1_000_000;
  // quiet cycles after the last result before touching registers or ending
  localparam int SETTLE_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  ttc_pkg::ttc_cmd_t cmd;
  logic              res_valid;
  logic              res_stall;
  ttc_pkg::ttc_res_t res;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [0:0]        cfg_data;

  int mismatch_count;
  int outstanding;
  int cycle_count;

  // idling switches for the sender and the receiver
  bit tx_idle_on;
  bit rx_idle_on;
  // one-shot request for a long receiver hold-off
  bit hold_req;

  text_terminal_cursor_engine_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ttc_draw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatch_count),
    .outstanding(outstanding)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a run that gets here has hung somewhere
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request; while held the
  // engine cannot finish draining its results and keeps its command input stalled
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // offer one item and hold it until the engine takes it; valid stays high
  // afterwards until the next call or a settle decides otherwise
  task automatic send_cmd(ttc_pkg::ttc_cmd_t c);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
    end
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic send(ttc_pkg::ttc_action_t a, logic [7:0] code, logic [7:0] x,
                      logic [7:0] y);
    ttc_pkg::ttc_cmd_t c;
    c.action = a;
    c.char_code = code;
    c.col = x;
    c.row = y;
    send_cmd(c);
  endtask

  // drop valid and wait until every expected draw command has come out
  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic set_modes(bit wrap, bit scroll, bit overlay);
    write_reg(ttc_pkg::REG_WRAP, wrap);
    write_reg(ttc_pkg::REG_SCROLL, scroll);
    write_reg(ttc_pkg::REG_OVERLAY, overlay);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly text and line control, with some noise codes, so the cursor travels the whole
  // page and scrolls; the rest moves the cursor, clears the screen or reads cells back
  function automatic ttc_pkg::ttc_cmd_t random_cmd();
    ttc_pkg::ttc_cmd_t c;
    int pick;
    int sub;
    c.action = ttc_pkg::ACT_CHAR;
    c.char_code = 8'($urandom);
    c.col = 8'($urandom);
    c.row = 8'($urandom);
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    if (pick < 78) begin
      if (sub < 58) begin
        c.char_code = 8'($urandom_range(ttc_pkg::CH_SPACE, ttc_pkg::CH_LAST_PRINT));
      end else if (sub < 67) c.char_code = ttc_pkg::CH_LF;
      else if (sub < 73) c.char_code = ttc_pkg::CH_CR;
      else if (sub < 81) c.char_code = ttc_pkg::CH_TAB;
      else if (sub < 89) c.char_code = ttc_pkg::CH_BS;
    end else if (pick < 86) begin
      c.action = ttc_pkg::ACT_SET_CURSOR;
      // usually on the page or one past the last column
      if (sub < 75) begin
        c.col = 8'($urandom_range(0, COLUMNS));
        c.row = 8'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 87) begin
      c.action = ttc_pkg::ACT_CLEAR_SCREEN;
    end else begin
      c.action = ttc_pkg::ACT_READ_CELL;
      if (sub < 80) begin
        c.col = 8'($urandom_range(0, COLUMNS - 1));
        c.row = 8'($urandom_range(0, ROWS - 1));
      end
    end
    return c;
  endfunction

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    cfg_write = 1'b0;
    cfg_index = ttc_pkg::REG_WRAP;
    cfg_data = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed part under reset modes: wrap on, scroll on, no overlay
    send(ttc_pkg::ACT_READ_CELL, 8'd0, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, 8'd72, 8'hff, 8'hff);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_SPACE, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_LAST_PRINT, 8'd0, 8'd0);
    // ignored codes below space and above the printable range
    send(ttc_pkg::ACT_CHAR, 8'd31, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, 8'd128, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, 8'd255, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_TAB, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_BS, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_CR, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_LF, 8'd0, 8'd0);
    // last cell of the page: wrap then scroll
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'(COLUMNS - 1), 8'(ROWS - 1));
    send(ttc_pkg::ACT_CHAR, 8'd90, 8'd0, 8'd0);
    send(ttc_pkg::ACT_READ_CELL, 8'd0, 8'(COLUMNS - 1), 8'(ROWS - 2));
    // off-page cursor homes on a glyph
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'hff, 8'hff);
    send(ttc_pkg::ACT_CHAR, 8'd97, 8'd0, 8'd0);
    // backspace from one past the last column lands on the page
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'(COLUMNS), 8'd3);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_BS, 8'd0, 8'd0);
    // backspace from far off the page homes
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'd100, 8'd2);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_BS, 8'd0, 8'd0);
    // newline from a row beyond the page scrolls
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'd5, 8'hff);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_LF, 8'd0, 8'd0);
    // tab with an off-page cursor homes
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'd70, 8'd1);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_TAB, 8'd0, 8'd0);
    send(ttc_pkg::ACT_READ_CELL, 8'd0, 8'hff, 8'hff);
    send(ttc_pkg::ACT_CLEAR_SCREEN, 8'd0, 8'd0, 8'd0);
    // backspace at column 0 does nothing
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_BS, 8'd0, 8'd0);
    settle();

    // no wrap, no scroll, overlay: cursor runs off the row end, newline rolls
    set_modes(1'b0, 1'b0, 1'b1);
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'(COLUMNS - 2), 8'(ROWS - 1));
    send(ttc_pkg::ACT_CHAR, 8'd120, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, 8'd121, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, 8'd122, 8'd0, 8'd0);
    send(ttc_pkg::ACT_SET_CURSOR, 8'd0, 8'(COLUMNS - 8), 8'(ROWS - 1));
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_TAB, 8'd0, 8'd0);
    send(ttc_pkg::ACT_CHAR, ttc_pkg::CH_LF, 8'd0, 8'd0);

    // random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: set_modes(1'b1, 1'b1, 1'b0);
        1: set_modes(1'b0, 1'b0, 1'b1);
        2: set_modes(1'b1, 1'b1, 1'b1);
        3: set_modes(1'b0, 1'b0, 1'b0);
        4: set_modes(1'($urandom), 1'($urandom), 1'($urandom));
        default: set_modes(1'b1, 1'b0, 1'b0);
      endcase
      // mix of idling patterns; the last two phases run flat out
      tx_idle_on = (phase == 0 || phase == 1 || phase == 3);
      rx_idle_on = (phase == 0 || phase == 2 || phase == 3);
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) send_cmd(random_cmd());
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
